// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSWQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cswq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSWQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cswq assertion failed");

`endif

// File: rtl/cswq_pkg.sv
package cswq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_BITS     = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int COUNT_W     = 17;
  localparam int SUM_W       = COUNT_W + 1;
  localparam int COUNT_MAX   = 65535;
  localparam int INIT_W      = 15;
  localparam int RC_W        = 16;
  localparam int TID_W       = 8;
  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic MODE_WAIT   = 1'b0;
  localparam logic MODE_SIGNAL = 1'b1;

  localparam logic [KIND_W-1:0] KIND_WAIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WOKEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAKE,
    ST_LAST
  } state_e;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/counting_semaphore_wait_queue.sv
// Counting semaphore with a FIFO of blocked thread ids.
// Input stream (s_axis): tuser[0] = mode (wait / signal), tdata carries the
// thread id and the signed release count n. Output stream (m_axis): tuser is
// the result kind; tlast marks the final result of an item.
// A wait gives one response: pass, blocked (id queued) or queue overflow.
// A signal wakes up to max(n,1) queued threads, oldest first, one result each,
// then a done result with the number woken; a negative n only echoes n.
// A wait, or a signal that wakes nobody, shows its result the cycle after the
// input transfer; a signal that wakes threads first reads the queue RAM in
// ST_READ and shows its first woken id from ST_WAKE.
// One item at a time: no new input is taken until the last result of an item
// is taken. For a signal that wakes threads, each woken id needs a read of the
// queue RAM (registered read) in ST_READ followed by its output in ST_WAKE.
// The count update uses one shared adder.
// While a result is stalled by m_axis_tready the block holds it and accepts
// nothing. The config channel loads the count and empties the queue; it is
// taken only when idle and wins over a same-cycle input transfer.
// Reset: count is zero, queue empty, no result pending.
module counting_semaphore_wait_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cswq_pkg::INIT_W-1:0]        cfg_data_i,      // initial_count
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cswq_pkg::IN_DATA_W-1:0]     s_axis_tdata,    // thread_id, release_count
  input  logic [0:0]                         s_axis_tuser,    // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cswq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,    // id, blocked, overflow,
                                                              // return_value, 6'b0
  output logic [cswq_pkg::KIND_W-1:0]        m_axis_tuser,    // kind
  output logic                               m_axis_tlast
);

  cswq_pkg::state_e state_q, state_d;

  logic signed [cswq_pkg::COUNT_W-1:0] count_q;
  logic [cswq_pkg::PTR_W-1:0]          head_q, tail_q;
  logic [cswq_pkg::ID_BITS-1:0]        queue_mem_q [cswq_pkg::QUEUE_DEPTH];
  logic [cswq_pkg::ID_BITS-1:0]        rd_q;
  logic [cswq_pkg::QCNT_W-1:0]         rem_q, wake_q;

  logic [cswq_pkg::KIND_W-1:0] res_kind_q;
  logic [cswq_pkg::TID_W-1:0]  res_id_q;
  logic                        res_blk_q, res_ovf_q;
  logic [cswq_pkg::RC_W-1:0]   res_rv_q;

  // input fields
  logic                          in_mode;
  logic [cswq_pkg::TID_W-1:0]    in_tid;
  logic signed [cswq_pkg::RC_W-1:0] in_rc;
  assign in_mode = s_axis_tuser[0];
  assign in_tid  = s_axis_tdata[cswq_pkg::TID_W-1:0];
  assign in_rc   = signed'(s_axis_tdata[cswq_pkg::TID_W +: cswq_pkg::RC_W]);

  logic in_fire, out_fire, cfg_fire;
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;

  // queue occupancy is -count when the count is negative
  logic [cswq_pkg::COUNT_W-1:0] neg_count;
  logic [cswq_pkg::QCNT_W-1:0]  queued;
  logic                         q_full;
  assign neg_count = cswq_pkg::COUNT_W'(-count_q);
  assign queued    = count_q[cswq_pkg::COUNT_W-1] ?
                     neg_count[cswq_pkg::QCNT_W-1:0] : '0;
  assign q_full    = (queued >= cswq_pkg::QCNT_W'(cswq_pkg::QUEUE_DEPTH));

  logic [cswq_pkg::RC_W-1:0]   amount;
  logic [cswq_pkg::QCNT_W-1:0] wake;
  logic                        rc_neg;
  assign rc_neg = in_rc[cswq_pkg::RC_W-1];
  assign amount = (in_rc == '0) ? cswq_pkg::RC_W'(1) : in_rc[cswq_pkg::RC_W-1:0];
  assign wake   = (amount < cswq_pkg::RC_W'(queued)) ?
                  amount[cswq_pkg::QCNT_W-1:0] : queued;

  // shared count adder: -1 for a wait, +amount for a signal
  logic signed [cswq_pkg::SUM_W-1:0] add_b, sum;
  logic signed [cswq_pkg::COUNT_W-1:0] count_upd;
  assign add_b = (in_mode == cswq_pkg::MODE_WAIT) ? -cswq_pkg::SUM_W'(1) :
                 signed'({2'b00, amount});
  assign sum   = {count_q[cswq_pkg::COUNT_W-1], count_q} + add_b;
  assign count_upd = (sum > cswq_pkg::SUM_W'(cswq_pkg::COUNT_MAX)) ?
                     cswq_pkg::COUNT_W'(cswq_pkg::COUNT_MAX) :
                     sum[cswq_pkg::COUNT_W-1:0];

  logic wait_pass;
  assign wait_pass = (count_q > 0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cswq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == cswq_pkg::MODE_WAIT || rc_neg || wake == '0) begin
            state_d = cswq_pkg::ST_LAST;
          end else begin
            state_d = cswq_pkg::ST_READ;
          end
        end
      end
      cswq_pkg::ST_READ: state_d = cswq_pkg::ST_WAKE;
      cswq_pkg::ST_WAKE: begin
        if (m_axis_tready) begin
          state_d = (rem_q == '0) ? cswq_pkg::ST_LAST : cswq_pkg::ST_READ;
        end
      end
      cswq_pkg::ST_LAST: begin
        if (m_axis_tready) begin
          state_d = cswq_pkg::ST_IDLE;
        end
      end
      default: state_d = cswq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cfg_ready_o   = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tuser  = res_kind_q;
    m_axis_tlast  = 1'b1;
    m_axis_tdata  = {6'b0, res_rv_q, res_ovf_q, res_blk_q, res_id_q};
    unique case (state_q)
      cswq_pkg::ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = ~cfg_valid_i;
      end
      cswq_pkg::ST_READ: begin
      end
      cswq_pkg::ST_WAKE: begin
        m_axis_tvalid = 1'b1;
        m_axis_tuser  = cswq_pkg::KIND_WOKEN;
        m_axis_tlast  = 1'b0;
        m_axis_tdata  = {6'b0, cswq_pkg::RC_W'(0), 1'b0, 1'b0, cswq_pkg::TID_W'(rd_q)};
      end
      cswq_pkg::ST_LAST: begin
        m_axis_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cswq_pkg::ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        count_q <= signed'({2'b00, cfg_data_i});
        head_q  <= '0;
        tail_q  <= '0;
      end else if (in_fire) begin
        if (in_mode == cswq_pkg::MODE_WAIT) begin
          if (wait_pass || !q_full) begin
            count_q <= count_upd;
          end
          if (!wait_pass && !q_full) begin
            tail_q <= cswq_pkg::next_ptr(tail_q);
          end
        end else if (!rc_neg) begin
          count_q <= count_upd;
          rem_q   <= wake;
        end
      end else if (state_q == cswq_pkg::ST_READ) begin
        head_q <= cswq_pkg::next_ptr(head_q);
        rem_q  <= rem_q - cswq_pkg::QCNT_W'(1);
      end
    end
  end

  // queue RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire && in_mode == cswq_pkg::MODE_WAIT && !wait_pass && !q_full) begin
      queue_mem_q[tail_q] <= in_tid[cswq_pkg::ID_BITS-1:0];
    end
    if (state_q == cswq_pkg::ST_READ) begin
      rd_q <= queue_mem_q[head_q];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      wake_q <= wake;
      if (in_mode == cswq_pkg::MODE_WAIT) begin
        res_kind_q <= cswq_pkg::KIND_WAIT;
        res_rv_q   <= '0;
        if (wait_pass) begin
          res_id_q  <= '0;
          res_blk_q <= 1'b0;
          res_ovf_q <= 1'b0;
        end else begin
          res_id_q  <= cswq_pkg::TID_W'(in_tid[cswq_pkg::ID_BITS-1:0]);
          res_blk_q <= ~q_full;
          res_ovf_q <= q_full;
        end
      end else begin
        res_kind_q <= cswq_pkg::KIND_DONE;
        res_id_q   <= '0;
        res_blk_q  <= 1'b0;
        res_ovf_q  <= 1'b0;
        res_rv_q   <= rc_neg ? in_rc[cswq_pkg::RC_W-1:0] : cswq_pkg::RC_W'(wake);
      end
    end else if (state_q == cswq_pkg::ST_WAKE && out_fire && rem_q == '0) begin
      res_kind_q <= cswq_pkg::KIND_DONE;
      res_id_q   <= '0;
      res_blk_q  <= 1'b0;
      res_ovf_q  <= 1'b0;
      res_rv_q   <= cswq_pkg::RC_W'(wake_q);
    end
  end

endmodule

// File: rtl/cswq_checker.sv
`include "assert_macros.svh"

module cswq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cswq_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                            m_axis_tlast
);

  // one item at a time: no input while a result is pending
  `CSWQ_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)

  `CSWQ_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni,
                   s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `CSWQ_ASSERT_IMP(a_wait_single, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tuser == cswq_pkg::KIND_WAIT, m_axis_tlast)

  `CSWQ_ASSERT_IMP(a_woken_not_last, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tuser == cswq_pkg::KIND_WOKEN, !m_axis_tlast)

  `CSWQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind counting_semaphore_wait_queue cswq_checker u_cswq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: verif/tb_counting_semaphore_wait_queue.sv
`timescale 1ns / 100ps

module tb_counting_semaphore_wait_queue;

  localparam int RANDOM_ITEMS = 334;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [cswq_pkg::KIND_W-1:0] kind;
    logic [cswq_pkg::TID_W-1:0]  id;
    logic                        blocked;
    logic                        overflow;
    logic [cswq_pkg::RC_W-1:0]   retval;
    logic                        last;
  } sem_result_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_pattern_e;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [cswq_pkg::INIT_W-1:0]     cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [cswq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [cswq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [cswq_pkg::KIND_W-1:0]     m_axis_tuser;
  logic                            m_axis_tlast;

  // expected results in output order, plus the semaphore state behind them
  sem_result_t                pending_results[$];
  int                         sem_count;
  logic [cswq_pkg::TID_W-1:0] parked_ids[cswq_pkg::QUEUE_DEPTH];
  logic [cswq_pkg::PTR_W-1:0] park_head;
  logic [cswq_pkg::PTR_W-1:0] park_tail;

  int fail_count;
  int items_sent;
  int burst_left;
  int idle_cycles;
  bit hold_req;

  counting_semaphore_wait_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic sem_result_t make_result(logic [cswq_pkg::KIND_W-1:0] kind,
                                              logic [cswq_pkg::TID_W-1:0] id,
                                              logic blk, logic ovf,
                                              logic [cswq_pkg::RC_W-1:0] rv,
                                              logic last);
    sem_result_t r;
    r.kind     = kind;
    r.id       = id;
    r.blocked  = blk;
    r.overflow = ovf;
    r.retval   = rv;
    r.last     = last;
    return r;
  endfunction

  task automatic predict_semaphore_results(logic mode, logic [cswq_pkg::TID_W-1:0] tid,
                                           logic signed [cswq_pkg::RC_W-1:0] n);
    int queued;
    int amount;
    int wake;
    queued = (sem_count < 0) ? -sem_count : 0;
    if (mode == cswq_pkg::MODE_WAIT) begin
      if (sem_count > 0) begin
        sem_count--;
        pending_results.push_back(make_result(cswq_pkg::KIND_WAIT, '0, 1'b0, 1'b0, '0, 1'b1));
      end else if (queued >= cswq_pkg::QUEUE_DEPTH) begin
        pending_results.push_back(make_result(cswq_pkg::KIND_WAIT, tid, 1'b0, 1'b1, '0, 1'b1));
      end else begin
        sem_count--;
        parked_ids[park_tail] = tid;
        park_tail = cswq_pkg::next_ptr(park_tail);
        pending_results.push_back(make_result(cswq_pkg::KIND_WAIT, tid, 1'b1, 1'b0, '0, 1'b1));
      end
    end else if (n < 0) begin
      pending_results.push_back(make_result(cswq_pkg::KIND_DONE, '0, 1'b0, 1'b0, n, 1'b1));
    end else begin
      amount = (n == 0) ? 1 : int'(n);
      wake = (amount < queued) ? amount : queued;
      sem_count = sem_count + amount;
      if (sem_count > cswq_pkg::COUNT_MAX) begin
        sem_count = cswq_pkg::COUNT_MAX;
      end
      for (int i = 0; i < wake; i++) begin
        pending_results.push_back(make_result(cswq_pkg::KIND_WOKEN, parked_ids[park_head],
                                              1'b0, 1'b0, '0, 1'b0));
        park_head = cswq_pkg::next_ptr(park_head);
      end
      pending_results.push_back(make_result(cswq_pkg::KIND_DONE, '0, 1'b0, 1'b0,
                                            cswq_pkg::RC_W'(wake), 1'b1));
    end
  endtask

  task automatic sender_idle();
    if (s_axis_tvalid) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // valid stays up inside a burst; a gap of random length, possibly none, follows when the burst runs out
  task automatic send_item(logic mode, logic [cswq_pkg::TID_W-1:0] tid,
                           logic signed [cswq_pkg::RC_W-1:0] n);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        sender_idle();
        repeat (gap) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {n, tid};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_semaphore_results(mode, tid, n);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_for_results();
    sender_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_initial_count(logic [cswq_pkg::INIT_W-1:0] value);
    wait_for_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sem_count = int'(value);
    park_head = '0;
    park_tail = '0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // count starts at zero out of reset
  task automatic test_wait_and_wake();
    send_item(cswq_pkg::MODE_WAIT, 8'h00, 16'sh7FFF);
    send_item(cswq_pkg::MODE_WAIT, 8'hFF, 16'sh8000);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h12, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h34, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h56, 16'sd0);
    send_item(cswq_pkg::MODE_WAIT, 8'h3C, 16'sd0);
    send_item(cswq_pkg::MODE_WAIT, 8'hC3, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h00, 16'sd2);
  endtask

  task automatic test_negative_release();
    load_initial_count('0);
    send_item(cswq_pkg::MODE_WAIT, 8'hA5, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'hFF, -16'sd1);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h00, 16'sh8000);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h5A, 16'sd0);
  endtask

  task automatic test_count_saturation();
    load_initial_count('1);
    send_item(cswq_pkg::MODE_WAIT, 8'h01, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h02, 16'sh7FFF);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h03, 16'sh7FFF);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h04, 16'sd0);
    send_item(cswq_pkg::MODE_WAIT, 8'h05, 16'sd0);
  endtask

  // move the pointers off zero first so the full queue wraps
  task automatic test_queue_overflow();
    load_initial_count('0);
    repeat (5) begin
      send_item(cswq_pkg::MODE_WAIT, cswq_pkg::TID_W'($urandom_range(0, 255)),
                cswq_pkg::RC_W'($urandom_range(0, 65535)));
    end
    send_item(cswq_pkg::MODE_SIGNAL, cswq_pkg::TID_W'($urandom_range(0, 255)), 16'sd5);
    while (sem_count > -cswq_pkg::QUEUE_DEPTH) begin
      send_item(cswq_pkg::MODE_WAIT, cswq_pkg::TID_W'($urandom_range(0, 255)),
                cswq_pkg::RC_W'($urandom_range(0, 65535)));
    end
    send_item(cswq_pkg::MODE_WAIT, 8'hFF, 16'sd0);
    send_item(cswq_pkg::MODE_WAIT, 8'h00, 16'sd0);
    send_item(cswq_pkg::MODE_SIGNAL, 8'h00, 16'sd40);
  endtask

  task automatic test_backpressure();
    load_initial_count(15'd2);
    hold_req = 1'b1;
    repeat (12) begin
      send_item(($urandom_range(0, 1) == 1) ? cswq_pkg::MODE_WAIT : cswq_pkg::MODE_SIGNAL,
                cswq_pkg::TID_W'($urandom_range(0, 255)),
                cswq_pkg::RC_W'($urandom_range(0, 3)));
    end
    wait_for_results();
    repeat (6) begin
      send_item(cswq_pkg::MODE_SIGNAL, cswq_pkg::TID_W'($urandom_range(0, 255)),
                cswq_pkg::RC_W'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_random_traffic();
    int start_count;
    int phase_len;
    int wait_pct;
    int pick;
    logic [cswq_pkg::INIT_W-1:0] init_val;
    logic signed [cswq_pkg::RC_W-1:0] n;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        init_val = cswq_pkg::INIT_W'($urandom_range(0, 4));
      end else if (pick < 70) begin
        init_val = '0;
      end else if (pick < 82) begin
        init_val = '1;
      end else begin
        init_val = cswq_pkg::INIT_W'($urandom_range(0, 32767));
      end
      load_initial_count(init_val);
      phase_len = $urandom_range(20, 60);
      if (phase_len > RANDOM_ITEMS - (items_sent - start_count)) begin
        phase_len = RANDOM_ITEMS - (items_sent - start_count);
      end
      wait_pct = $urandom_range(50, 90);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          n = cswq_pkg::RC_W'($urandom_range(0, 3));
        end else if (pick < 75) begin
          n = cswq_pkg::RC_W'($urandom_range(4, 40));
        end else if (pick < 92) begin
          n = cswq_pkg::RC_W'($urandom_range(32768, 65535));
        end else begin
          n = cswq_pkg::RC_W'($urandom_range(41, 32767));
        end
        send_item(($urandom_range(0, 99) < wait_pct) ? cswq_pkg::MODE_WAIT :
                  cswq_pkg::MODE_SIGNAL, cswq_pkg::TID_W'($urandom_range(0, 255)), n);
      end
    end
  endtask

  initial begin : receiver
    rx_pattern_e pattern;
    int          pattern_left;
    int          hold_left;
    logic        rdy;
    m_axis_tready = 1'b0;
    pattern = RX_ALWAYS;
    pattern_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
        if (hold_left == 0) begin
          hold_req = 1'b0;
        end
      end else begin
        if (pattern_left == 0) begin
          pattern = rx_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        case (pattern)
          RX_ALWAYS: rdy = 1'b1;
          RX_HALF:   rdy = ($urandom_range(0, 1) == 1);
          RX_MOSTLY: rdy = ($urandom_range(0, 99) < 85);
          default:   rdy = ($urandom_range(0, 99) < 20);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // m_axis_tdata: [7:0] id, [8] blocked, [9] overflow, [25:10] return value
  always @(posedge clk_i) begin : check_results
    sem_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d id %0d", m_axis_tuser,
               m_axis_tdata[7:0]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[7:0] !== want.id) begin
          $error("woken_or_blocked_id: expected %0d, got %0d", want.id, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[8] !== want.blocked) begin
          $error("blocked: expected %0d, got %0d", want.blocked, m_axis_tdata[8]);
          fail_count++;
        end
        if (m_axis_tdata[9] !== want.overflow) begin
          $error("queue_overflow: expected %0d, got %0d", want.overflow, m_axis_tdata[9]);
          fail_count++;
        end
        if (m_axis_tdata[25:10] !== want.retval) begin
          $error("return_value: expected %0d, got %0d", $signed(want.retval),
                 $signed(m_axis_tdata[25:10]));
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // any transfer on any channel counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_req      = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    burst_left    = 0;
    sem_count     = 0;
    park_head     = '0;
    park_tail     = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_wait_and_wake();
    test_negative_release();
    test_count_saturation();
    test_queue_overflow();
    test_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
